/* hw/rtl/tcce_pkg.sv */
// Shared types and constants for the text console cursor engine.
// No dependencies; compiled first.
`default_nettype none

package tcce_pkg;

  localparam int MAX_COLS_DEF = 64;
  localparam int MAX_ROWS_DEF = 32;

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 7;

  localparam logic [CFG_IW-1:0] REG_ENABLE  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_COLUMNS = 2'd1;
  localparam logic [CFG_IW-1:0] REG_ROWS    = 2'd2;

  localparam logic [6:0] COLUMNS_RESET = 7'd50;
  localparam logic [5:0] ROWS_RESET    = 6'd30;

  localparam logic ACT_DRAW   = 1'b0;
  localparam logic ACT_SCROLL = 1'b1;

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_FIRST = 8'h20;
  localparam logic [7:0] CHAR_LAST  = 8'h7e;
  localparam logic [6:0] GLYPH_SPACE = 7'h20;

  localparam int QDEPTH = 2;

  typedef enum logic [2:0] {
    K_LF,
    K_CR,
    K_TAB,
    K_PRINT,
    K_OTHER
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [6:0] glyph;
  } cmd_t;

  typedef enum logic {
    ST_CMD,
    ST_NL
  } back_st_t;

endpackage

`default_nettype wire

/* hw/rtl/tcce_if.sv */
// Valid/ready channel interfaces: console byte in, cell command out.
// No dependencies.
`default_nettype none

interface tcce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface tcce_out_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [5:0] cell_col;
  logic [4:0] cell_row;
  logic [6:0] glyph_code;
  logic       last;

  modport source (output valid, output action, output cell_col, output cell_row,
                  output glyph_code, output last, input ready);
  modport sink   (input valid, input action, input cell_col, input cell_row,
                  input glyph_code, input last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/tcce_front.sv */
// Front end: takes console bytes, classifies them and queues commands.
// Depends on tcce_pkg and tcce_in_if.
`default_nettype none

module tcce_front import tcce_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  enable,
  tcce_in_if.sink    char_in,
  input  wire logic  pop,
  output cmd_t       head,
  output logic       head_valid
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNTW = $clog2(QDEPTH + 1);

  cmd_t            mem [QDEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;
  cmd_t            cls;
  logic            push;

  always_comb begin
    cls.glyph = char_in.char_code[6:0];
    if (char_in.char_code == CHAR_LF) begin
      cls.kind = K_LF;
    end else if (char_in.char_code == CHAR_CR) begin
      cls.kind = K_CR;
    end else if (char_in.char_code == CHAR_TAB) begin
      cls.kind = K_TAB;
    end else if (char_in.char_code >= CHAR_FIRST && char_in.char_code <= CHAR_LAST) begin
      cls.kind = K_PRINT;
    end else begin
      cls.kind = K_OTHER;
    end
  end

  assign char_in.ready = (count != CNTW'(QDEPTH));
  // bytes transferred while disabled are dropped
  assign push = char_in.valid && char_in.ready && enable;
  assign head_valid = (count != '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNTW'(push) - CNTW'(pop);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tcce_back.sv */
// Back end: runs queued commands against the cursor, emits cell commands.
// Depends on tcce_pkg and tcce_out_if.
`default_nettype none

module tcce_back import tcce_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  localparam int CW = $clog2(MAX_COLS),
  localparam int RW = $clog2(MAX_ROWS)
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [CW:0] nc,
  input  wire logic [RW:0] nr,
  input  wire cmd_t        head,
  input  wire logic        head_valid,
  output logic             pop,
  tcce_out_if.source       cmd_out
);

  back_st_t      state;
  back_st_t      state_next;
  logic [CW-1:0] col;
  logic [CW-1:0] col_next;
  logic [RW-1:0] line;
  logic [RW-1:0] line_next;

  logic          can_load;
  logic          go;
  logic [CW:0]   col_inc;
  logic          col_end;
  logic          col_at_end;
  logic [RW:0]   line_inc;
  logic          scroll_need;
  logic [RW-1:0] last_row;
  logic          tab_stop;
  logic          to_nl;

  logic          emit;
  logic          r_action;
  logic [6:0]    r_glyph;
  logic          r_last;

  assign can_load    = !cmd_out.valid || cmd_out.ready;
  assign go          = head_valid && can_load;
  assign col_inc     = {1'b0, col} + 1'b1;
  assign col_end     = (col_inc >= nc);
  assign col_at_end  = ({1'b0, col} >= nc);
  assign line_inc    = {1'b0, line} + 1'b1;
  assign scroll_need = (line_inc >= nr);
  assign last_row    = RW'(nr - 1'b1);
  assign tab_stop    = (col_inc[2:0] == 3'd0);

  always_comb begin
    state_next = state;
    case (state)
      ST_CMD: begin
        if (to_nl) state_next = ST_NL;
      end
      ST_NL: begin
        if (can_load) state_next = ST_CMD;
      end
      default: state_next = ST_CMD;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    emit      = 1'b0;
    to_nl     = 1'b0;
    r_action  = ACT_DRAW;
    r_glyph   = head.glyph;
    r_last    = 1'b1;
    col_next  = col;
    line_next = line;
    case (state)
      ST_NL: begin
        if (can_load) begin
          emit      = 1'b1;
          r_action  = ACT_SCROLL;
          col_next  = '0;
          line_next = last_row;
          pop       = 1'b1;
        end
      end
      ST_CMD: begin
        if (go) begin
          case (head.kind)
            K_CR: begin
              col_next = '0;
              pop      = 1'b1;
            end
            K_LF: begin
              col_next = '0;
              pop      = 1'b1;
              if (scroll_need) begin
                emit      = 1'b1;
                r_action  = ACT_SCROLL;
                line_next = last_row;
              end else begin
                line_next = line_inc[RW-1:0];
              end
            end
            K_PRINT, K_OTHER, K_TAB: begin
              if (head.kind == K_TAB) r_glyph = GLYPH_SPACE;
              if (head.kind == K_TAB && col_at_end) begin
                // tab from beyond the last column: plain new line
                col_next = '0;
                pop      = 1'b1;
                if (scroll_need) begin
                  emit      = 1'b1;
                  r_action  = ACT_SCROLL;
                  line_next = last_row;
                end else begin
                  line_next = line_inc[RW-1:0];
                end
              end else if (col_end) begin
                emit = (head.kind != K_OTHER);
                if (!scroll_need) begin
                  col_next  = '0;
                  line_next = line_inc[RW-1:0];
                  pop       = 1'b1;
                end else if (emit) begin
                  // draw now, scroll from ST_NL once the output can load
                  r_last = 1'b0;
                  to_nl  = 1'b1;
                end else begin
                  emit      = 1'b1;
                  r_action  = ACT_SCROLL;
                  col_next  = '0;
                  line_next = last_row;
                  pop       = 1'b1;
                end
              end else begin
                emit     = (head.kind != K_OTHER);
                col_next = col_inc[CW-1:0];
                if (head.kind == K_TAB && !tab_stop) begin
                  r_last = 1'b0;
                end else begin
                  pop = 1'b1;
                end
              end
            end
            default: pop = 1'b1;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CMD;
      col   <= '0;
      line  <= '0;
    end else begin
      state <= state_next;
      col   <= col_next;
      line  <= line_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_out.valid <= 1'b0;
    end else if (emit) begin
      cmd_out.valid <= 1'b1;
    end else if (cmd_out.ready) begin
      cmd_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      cmd_out.action <= r_action;
      cmd_out.last   <= r_last;
      if (r_action == ACT_SCROLL) begin
        cmd_out.cell_col   <= '0;
        cmd_out.cell_row   <= '0;
        cmd_out.glyph_code <= '0;
      end else begin
        cmd_out.cell_col   <= 6'(col);
        cmd_out.cell_row   <= 5'(line);
        cmd_out.glyph_code <= r_glyph;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/text_console_cursor_engine.sv */
// A byte's first cell command passes the front-end queue, then the registered
// cmd_out stage. Throughput: the back-end sequencer issues one command per cycle
// unless cmd_out stalls, so one byte per cycle for printable and plain codes; a
// printable wrap that scrolls issues a draw, then a scroll from ST_NL, a tab one
// space per column filled plus a scroll at the bottom, while the queue takes new
// bytes. Reset: disabled, 50 columns by 30 rows, cursor at column 0, row 0.
`default_nettype none

module text_console_cursor_engine import tcce_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data,
  tcce_in_if.sink                char_in,
  tcce_out_if.source             cmd_out
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);

  logic        enable;
  logic [6:0]  columns;
  logic [5:0]  rows;
  logic [CW:0] nc;
  logic [RW:0] nr;
  cmd_t        head;
  logic        head_valid;
  logic        pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable  <= 1'b0;
      columns <= COLUMNS_RESET;
      rows    <= ROWS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:  enable  <= cfg_data[0];
        REG_COLUMNS: columns <= cfg_data[6:0];
        REG_ROWS:    rows    <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (columns == '0) begin
      nc = (CW+1)'(1);
    end else if (int'(columns) > MAX_COLS) begin
      nc = (CW+1)'(MAX_COLS);
    end else begin
      nc = (CW+1)'(columns);
    end
    if (rows == '0) begin
      nr = (RW+1)'(1);
    end else if (int'(rows) > MAX_ROWS) begin
      nr = (RW+1)'(MAX_ROWS);
    end else begin
      nr = (RW+1)'(rows);
    end
  end

  tcce_front u_front (
    .clk        (clk),
    .rst        (rst),
    .enable     (enable),
    .char_in    (char_in),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  tcce_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .nc         (nc),
    .nr         (nr),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .cmd_out    (cmd_out)
  );

endmodule

`default_nettype wire

/* tb/sv/text_console_cursor_engine_tb.sv */
// Self-checking bench for text_console_cursor_engine: console bytes in,
// cell commands out, checked against a cursor predictor kept in the bench.
// Depends on tcce_pkg, tcce_in_if / tcce_out_if and the engine RTL.
`timescale 1ns / 1ps

module text_console_cursor_engine_tb;
  import tcce_pkg::*;

  localparam logic [CFG_IW-1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_BYTES = 390;
  localparam int SCRIPT_LEN = 35;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic       action;
    logic [5:0] col;
    logic [4:0] row;
    logic [6:0] glyph;
    logic       last;
  } cell_cmd_t;

  typedef struct packed {
    logic              is_reg;
    logic [CFG_IW-1:0] idx;
    logic [CFG_DW-1:0] val;
    logic [7:0]        code;
    logic              typed;
    cell_cmd_t         want;
  } script_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  tcce_in_if  char_if ();
  tcce_out_if cmd_if ();

  text_console_cursor_engine dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .char_in   (char_if),
    .cmd_out   (cmd_if)
  );

  // shadow registers and cursor
  logic       en_sh;
  logic [6:0] cols_sh;
  logic [5:0] rows_sh;
  logic [5:0] cur_col;
  logic [4:0] cur_row;

  cell_cmd_t cmds_due[$];
  cell_cmd_t step_cmds[$];
  int errors;
  int byte_count;
  bit in_calm;
  bit out_calm;
  script_row_t script [SCRIPT_LEN];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(64'd10_000_000);
    $display("text_console_cursor_engine_tb NOT OK");
    $finish;
  end

  task automatic note_error(input string msg);
    if (errors < MAX_PRINTED) $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic int gap_len(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  function automatic void emit(input logic act, input int c, input int r,
                               input logic [6:0] g);
    cell_cmd_t cmd;
    cmd.action = act;
    cmd.col    = c[5:0];
    cmd.row    = r[4:0];
    cmd.glyph  = g;
    cmd.last   = 1'b0;
    step_cmds.push_back(cmd);
  endfunction

  function automatic void next_line(input int nrows, inout int c, inout int r);
    c = 0;
    r++;
    if (r >= nrows) begin
      emit(ACT_SCROLL, 0, 0, 7'd0);
      r = nrows - 1;
    end
  endfunction

  // cursor predictor: fills step_cmds with the commands one byte causes
  function automatic void advance_cursor(input logic [7:0] code);
    int ncols;
    int nrows;
    int c;
    int r;
    int stop;
    cell_cmd_t tail;
    step_cmds.delete();
    if (!en_sh) return;
    ncols = (cols_sh == 0) ? 1 : (cols_sh > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(cols_sh);
    nrows = (rows_sh == 0) ? 1 : (rows_sh > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(rows_sh);
    c = cur_col;
    r = cur_row;
    if (code == CHAR_LF) begin
      next_line(nrows, c, r);
    end else if (code == CHAR_CR) begin
      c = 0;
    end else if (code == CHAR_TAB) begin
      stop = (c + 8) & ~7;
      while (c < stop && c < ncols) begin
        emit(ACT_DRAW, c, r, GLYPH_SPACE);
        c++;
      end
      if (c >= ncols) next_line(nrows, c, r);
    end else begin
      if (code >= CHAR_FIRST && code <= CHAR_LAST) emit(ACT_DRAW, c, r, code[6:0]);
      c++;
      if (c >= ncols) next_line(nrows, c, r);
    end
    if (step_cmds.size() > 0) begin
      tail = step_cmds.pop_back();
      tail.last = 1'b1;
      step_cmds.push_back(tail);
    end
    cur_col = c[5:0];
    cur_row = r[4:0];
  endfunction

  task automatic settle(input int extra);
    @(negedge clk);
    char_if.valid <= 1'b0;
    while (cmds_due.size() > 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    settle(DRAIN_CYCLES);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ENABLE:  en_sh = val[0];
      REG_COLUMNS: cols_sh = val;
      REG_ROWS:    rows_sh = val[5:0];
      default: ;
    endcase
  endtask

  task automatic send_byte(input logic [7:0] code, input logic typed, input cell_cmd_t want);
    int g;
    g = gap_len(in_calm);
    @(negedge clk);
    if (g > 0) begin
      char_if.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    char_if.valid     <= 1'b1;
    char_if.char_code <= code;
    do @(posedge clk); while (!char_if.ready);
    byte_count++;
    advance_cursor(code);
    if (typed) cmds_due.push_back(want);
    else foreach (step_cmds[i]) cmds_due.push_back(step_cmds[i]);
  endtask

  function automatic script_row_t reg_row(input logic [CFG_IW-1:0] idx,
                                          input logic [CFG_DW-1:0] val);
    script_row_t s;
    s = '0;
    s.is_reg = 1'b1;
    s.idx    = idx;
    s.val    = val;
    return s;
  endfunction

  function automatic script_row_t byte_row(input logic [7:0] code);
    script_row_t s;
    s = '0;
    s.code = code;
    return s;
  endfunction

  function automatic script_row_t draw_row(input logic [7:0] code, input logic [5:0] c,
                                           input logic [4:0] r);
    script_row_t s;
    s = byte_row(code);
    s.typed = 1'b1;
    s.want  = '{ACT_DRAW, c, r, code[6:0], 1'b1};
    return s;
  endfunction

  // output side: random back-pressure
  initial begin : sink_side
    int stall_left;
    stall_left = 0;
    cmd_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        cmd_if.ready <= 1'b0;
        stall_left--;
      end else begin
        cmd_if.ready <= 1'b1;
        stall_left = gap_len(out_calm);
      end
    end
  end

  always @(posedge clk) begin : cmd_check
    cell_cmd_t got;
    cell_cmd_t want;
    if (!rst && cmd_if.valid && cmd_if.ready) begin
      got = '{cmd_if.action, cmd_if.cell_col, cmd_if.cell_row, cmd_if.glyph_code, cmd_if.last};
      if (cmds_due.size() == 0) begin
        note_error($sformatf("unexpected command %h", got));
      end else begin
        want = cmds_due.pop_front();
        if (got.action !== want.action)
          note_error($sformatf("action %b, want %b", got.action, want.action));
        if (got.col !== want.col)
          note_error($sformatf("cell_col %0d, want %0d", got.col, want.col));
        if (got.row !== want.row)
          note_error($sformatf("cell_row %0d, want %0d", got.row, want.row));
        if (got.glyph !== want.glyph)
          note_error($sformatf("glyph_code %h, want %h", got.glyph, want.glyph));
        if (got.last !== want.last)
          note_error($sformatf("last %b, want %b", got.last, want.last));
      end
    end
  end

  initial begin : stimulus
    int n;
    int phase;
    logic [CFG_DW-1:0] v;
    errors = 0;
    byte_count = 0;
    in_calm = 1'b0;
    out_calm = 1'b0;
    en_sh = 1'b0;
    cols_sh = COLUMNS_RESET;
    rows_sh = ROWS_RESET;
    cur_col = '0;
    cur_row = '0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    char_if.valid = 1'b0;
    char_if.char_code = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    script = '{
      byte_row(8'h41),                    // disabled: ignored
      reg_row(REG_ENABLE, 7'd1),
      draw_row(8'h41, 6'd0, 5'd0),
      draw_row(8'h20, 6'd1, 5'd0),
      draw_row(8'h7e, 6'd2, 5'd0),
      byte_row(8'h7f),
      byte_row(8'h00),
      byte_row(8'hff),
      byte_row(CHAR_TAB),                 // spaces up to column 8
      byte_row(CHAR_TAB),                 // full tab stop
      byte_row(8'h1f),
      reg_row(REG_COLUMNS, 7'd10),        // cursor now past last column
      byte_row(8'h7a),
      byte_row(CHAR_TAB),
      reg_row(REG_COLUMNS, 7'd4),
      byte_row(CHAR_TAB),                 // tab beyond edge: new line only
      reg_row(REG_ROWS, 7'd1),
      byte_row(CHAR_LF),                  // row beyond edge: scroll
      reg_row(REG_COLUMNS, 7'd0),
      reg_row(REG_ROWS, 7'd0),
      byte_row(8'h5a),
      reg_row(REG_COLUMNS, 7'd127),
      reg_row(REG_ROWS, 7'd127),
      byte_row(CHAR_TAB),
      byte_row(CHAR_TAB),
      byte_row(CHAR_TAB),
      byte_row(CHAR_TAB),
      byte_row(CHAR_TAB),
      byte_row(CHAR_TAB),
      byte_row(CHAR_TAB),
      byte_row(CHAR_TAB),                 // last stop: wrap
      reg_row(REG_UNUSED, 7'd127),
      reg_row(REG_ENABLE, 7'd0),
      byte_row(CHAR_LF),
      byte_row(CHAR_CR)
    };
    foreach (script[i]) begin
      if (script[i].is_reg) write_reg(script[i].idx, script[i].val);
      else send_byte(script[i].code, script[i].typed, script[i].want);
    end

    byte_count = 0;
    phase = 0;
    while (byte_count < RANDOM_BYTES) begin
      write_reg(REG_ENABLE, ($urandom_range(0, 7) != 0) ? 7'd1 : 7'd0);
      case ($urandom_range(0, 9))
        0: v = 7'd0;
        1: v = 7'd1;
        2: v = 7'd8;
        3: v = 7'd9;
        4: v = 7'd64;
        5: v = 7'd127;
        6: v = 7'($urandom_range(65, 127));
        default: v = 7'($urandom_range(2, 63));
      endcase
      write_reg(REG_COLUMNS, v);
      case ($urandom_range(0, 7))
        0: v = 7'd0;
        1: v = 7'd1;
        2: v = 7'd32;
        3: v = 7'($urandom_range(33, 127));
        default: v = 7'($urandom_range(2, 31));
      endcase
      write_reg(REG_ROWS, v);
      if ($urandom_range(0, 5) == 0) write_reg(REG_UNUSED, 7'($urandom));
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      n = $urandom_range(15, 50);
      v = '0;
      for (int k = 0; k < n; k++) begin
        if ((phase == 1 && k == n / 2) || $urandom_range(0, 59) == 0) settle(0);
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8: v = 7'($urandom_range(32, 126));
          9, 10, 11: send_byte(CHAR_TAB, 1'b0, '0);
          12, 13: send_byte(CHAR_LF, 1'b0, '0);
          14: send_byte(CHAR_CR, 1'b0, '0);
          default: send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        endcase
        // printable pick sends here so the case above stays one call per branch
        if (v >= 7'd32 && v <= 7'd126) begin
          send_byte({1'b0, v}, 1'b0, '0);
          v = '0;
        end
      end
      phase++;
    end

    settle(DRAIN_CYCLES);
    if (errors == 0 && cmds_due.size() == 0) begin
      $display("text_console_cursor_engine_tb OK");
    end else begin
      $display("text_console_cursor_engine_tb NOT OK");
    end
    $finish;
  end

endmodule
